// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the positional list store.
// No dependencies; include this file inside a module that has clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/plst_pkg.sv
// Package for the positional list store: action and status codes, the
// sequencer state type and the request and result word structs. No dependencies.
`timescale 1ns / 1ps

package plst_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_ENTRY_WIDTH = 32;

  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_MOVE,
    S_DEL_CAP,
    S_DEL_STEP,
    S_DEL_MOVE,
    S_RD_CAP
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] write_value;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] item_count;
    status_t            status;
  } result_t;

endpackage

// File: rtl/plst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/positional_list_store_unit.sv
// Top level of the positional list store: sequencer, entry count and result register.
// Depends on plst_pkg, plst_ram and assert_macros.svh.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and the receiver cannot stall
// it. All entries live in one RAM with one write and one registered read
// port, and entries are moved one at a time, each read in a step state and
// written in a move state. A clear or any rejected word is answered without
// leaving the idle state. The entry RAM needs no clearing after reset.
module positional_list_store_unit
  import plst_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

`include "assert_macros.svh"

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          idx, idx_next;
  logic [CW-1:0]          pos_q, pos_q_next;
  logic [ENTRY_WIDTH-1:0] val_q, val_q_next;
  logic [ENTRY_WIDTH-1:0] rd_q, rd_q_next;
  logic                   done_next;
  result_t                result_next;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  logic [CMPW-1:0]        pos_ext;
  logic [CMPW-1:0]        cnt_ext;
  logic [CW-1:0]          pos_c;
  logic [CW-1:0]          idx_dec;
  logic [CW-1:0]          idx_inc;

  logic                   full_word;
  logic                   fail_word;
  logic                   full_count;

  assign pos_ext = CMPW'(request.position);
  assign cnt_ext = CMPW'(count);
  assign pos_c   = CW'(pos_ext);
  assign idx_dec = idx - 1'b1;
  assign idx_inc = idx + 1'b1;
  assign busy    = (state != S_IDLE);

  assign full_word  = done && (result.status == ST_FULL);
  assign fail_word  = done && (result.status != ST_DONE);
  assign full_count = (result.item_count == COUNT_W'(CAPACITY));

  plst_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    pos_q  <= pos_q_next;
    val_q  <= val_q_next;
    rd_q   <= rd_q_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    pos_q_next  = pos_q;
    val_q_next  = val_q;
    rd_q_next   = rd_q;
    done_next   = 1'b0;
    result_next = result;
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = pos_c[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          result_next.read_value = '0;
          result_next.item_count = COUNT_W'(count);
          result_next.status     = ST_DONE;
          case (request.action)
            ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                result_next.status = ST_BAD_POS;
                done_next          = 1'b1;
              end else if (count == CW'(CAPACITY)) begin
                result_next.status = ST_FULL;
                done_next          = 1'b1;
              end else begin
                pos_q_next = pos_c;
                val_q_next = ENTRY_WIDTH'(request.write_value);
                idx_next   = count;
                state_next = S_INS_STEP;
              end
            end
            ACT_DELETE, ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                result_next.status = ST_BAD_POS;
                done_next          = 1'b1;
              end else begin
                // The RAM read of the addressed entry is issued now.
                pos_q_next = pos_c;
                state_next = (request.action == ACT_DELETE) ? S_DEL_CAP : S_RD_CAP;
              end
            end
            ACT_CLEAR: begin
              count_next             = '0;
              result_next.item_count = '0;
              done_next              = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // Insert walks down from the old end, moving each entry up by one.
      S_INS_STEP: begin
        if (idx == pos_q) begin
          ram_we                 = 1'b1;
          ram_waddr              = pos_q[AW-1:0];
          ram_wdata              = val_q;
          count_next             = count + 1'b1;
          result_next.read_value = '0;
          result_next.item_count = COUNT_W'(count + 1'b1);
          result_next.status     = ST_DONE;
          done_next              = 1'b1;
          state_next             = S_IDLE;
        end else begin
          ram_raddr  = idx_dec[AW-1:0];
          state_next = S_INS_MOVE;
        end
      end

      S_INS_MOVE: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_dec;
        state_next = S_INS_STEP;
      end

      S_DEL_CAP: begin
        rd_q_next  = ram_rdata;
        idx_next   = pos_q;
        state_next = S_DEL_STEP;
      end

      // Delete walks up from the removed slot, moving each entry down by one.
      S_DEL_STEP: begin
        if (idx_inc < count) begin
          ram_raddr  = idx_inc[AW-1:0];
          state_next = S_DEL_MOVE;
        end else begin
          count_next             = count - 1'b1;
          result_next.read_value = VALUE_W'(rd_q);
          result_next.item_count = COUNT_W'(count - 1'b1);
          result_next.status     = ST_DONE;
          done_next              = 1'b1;
          state_next             = S_IDLE;
        end
      end

      S_DEL_MOVE: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[AW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx_inc;
        state_next = S_DEL_STEP;
      end

      S_RD_CAP: begin
        result_next.read_value = VALUE_W'(ram_rdata);
        result_next.item_count = COUNT_W'(count);
        result_next.status     = ST_DONE;
        done_next              = 1'b1;
        state_next             = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `ASSERT_IMPL(a_full_count, full_word, full_count, "full status with list not full")
  `ASSERT_IMPL(a_fail_zero, fail_word, result.read_value == '0, "failed word returned a value")
  `ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted word stalled")

endmodule

// File: tb/positional_list_store_checker.sv
// Checker for the positional list store: watches the request and result channels,
// keeps its own copy of the list, and compares every result word. Depends on plst_pkg.
`timescale 1ns / 1ps

module positional_list_store_checker
  import plst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  request_t request,
  input  logic     done,
  input  result_t  result,
  output int       mismatch_count,
  output int       outstanding
);

  localparam int SLOTS = DEF_CAPACITY;

  logic [VALUE_W-1:0] list_entries [SLOTS];
  int                 list_len = 0;
  result_t            pending_results [$];
  int                 fail_tally = 0;
  int                 pending_depth = 0;

  assign mismatch_count = fail_tally;
  assign outstanding    = pending_depth;

  task automatic report_mismatch(input string what);
    fail_tally++;
    // Keep the log short if the design is badly broken.
    if (fail_tally <= 30) $display("%0t ns: %s", $time, what);
  endtask

  // Applies one request word to the local list and returns the result it should give.
  task automatic apply_list_action(input request_t req, output result_t res);
    int pos;
    pos = int'(req.position);
    res.read_value = '0;
    res.status     = ST_DONE;
    case (req.action)
      ACT_INSERT: begin
        // A position past the end is rejected before the full check.
        if (pos > list_len) begin
          res.status = ST_BAD_POS;
        end else if (list_len >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_entries[i] = list_entries[i - 1];
          list_entries[pos] = req.write_value;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          res.read_value = list_entries[pos];
          for (int i = pos; i + 1 < list_len; i++) list_entries[i] = list_entries[i + 1];
          list_len--;
        end
      end
      ACT_READ: begin
        if (pos >= list_len) res.status = ST_BAD_POS;
        else res.read_value = list_entries[pos];
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.item_count = COUNT_W'(list_len);
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t oldest;
    if (rst) begin
      list_len = 0;
      pending_results.delete();
      pending_depth <= 0;
    end else begin
      if (start && !busy) begin
        apply_list_action(request, predicted);
        pending_results.push_back(predicted);
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word arrived with none expected");
        end else begin
          oldest = pending_results.pop_front();
          if (result.read_value !== oldest.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      result.read_value, oldest.read_value));
          if (result.item_count !== oldest.item_count)
            report_mismatch($sformatf("item_count %0d, expected %0d",
                                      result.item_count, oldest.item_count));
          if (result.status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, oldest.status));
        end
      end
      pending_depth <= pending_results.size();
    end
  end

endmodule

// File: tb/positional_list_store_unit_tb.sv
// Top of the positional list store testbench: clock, reset, request stimulus and verdict.
// Depends on plst_pkg, positional_list_store_unit and positional_list_store_checker.
`timescale 1ns / 1ps

module positional_list_store_unit_tb;
  import plst_pkg::*;

  localparam int SLOTS       = DEF_CAPACITY;
  localparam int TOTAL_WORDS = 1050;
  localparam int CALM_TAIL   = 150;

  typedef enum int {
    PH_BALANCED,
    PH_GROW,
    PH_SHRINK
  } phase_kind_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;
  int       mismatches;
  int       outstanding;

  int       list_fill = 0;
  int       words_sent = 0;
  bit       allow_gaps = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_store_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  positional_list_store_checker u_list_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  // Offers one word and returns at the edge that takes it. The entry count kept
  // here only steers the stimulus: the choice of positions and how long a fill runs.
  task automatic send_word(input action_t act, input int unsigned pos,
                           input logic [VALUE_W-1:0] val);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    request <= '{action: act, position: POS_W'(pos), write_value: val};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    case (act)
      ACT_INSERT: if (pos <= list_fill && list_fill < SLOTS) list_fill++;
      ACT_DELETE: if (pos < list_fill) list_fill--;
      ACT_CLEAR:  list_fill = 0;
      default:    ;
    endcase
    words_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic int unsigned pick_position(input action_t act);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(0, 127);
    if (r < 20) begin
      case ($urandom_range(0, 2))
        0:       return list_fill;
        1:       return (list_fill == 0) ? 0 : list_fill - 1;
        default: return 0;
      endcase
    end
    if (act == ACT_INSERT) return $urandom_range(0, list_fill);
    return (list_fill == 0) ? 0 : $urandom_range(0, list_fill - 1);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_t pick_action(input phase_kind_t kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_GROW: begin
        if (r < 70) return ACT_INSERT;
        if (r < 85) return ACT_READ;
        if (r < 99) return ACT_DELETE;
        return ACT_CLEAR;
      end
      PH_SHRINK: begin
        if (r < 15) return ACT_INSERT;
        if (r < 45) return ACT_READ;
        if (r < 99) return ACT_DELETE;
        return ACT_CLEAR;
      end
      default: begin
        if (r < 40) return ACT_INSERT;
        if (r < 65) return ACT_DELETE;
        if (r < 97) return ACT_READ;
        return ACT_CLEAR;
      end
    endcase
  endfunction

  // Grows the list to capacity, then probes a full list.
  task automatic fill_and_probe();
    while (list_fill < SLOTS) send_word(ACT_INSERT, $urandom_range(0, list_fill), pick_value());
    send_word(ACT_INSERT, $urandom_range(0, SLOTS), pick_value());
    send_word(ACT_INSERT, SLOTS, pick_value());
    send_word(ACT_INSERT, SLOTS + 1, pick_value());
    send_word(ACT_READ, SLOTS - 1, '0);
    send_word(ACT_READ, SLOTS, '0);
    send_word(ACT_DELETE, SLOTS - 1, '0);
  endtask

  initial begin
    int          phase_no;
    int          run_len;
    phase_kind_t kind;
    action_t     act;
    phase_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: empty list, ends and middle, bad positions, clear.
    send_word(ACT_CLEAR, 0, '0);
    send_word(ACT_READ, 0, '0);
    send_word(ACT_DELETE, 0, '0);
    send_word(ACT_INSERT, 1, 32'h1234_5678);
    send_word(ACT_INSERT, 0, '0);
    send_word(ACT_INSERT, 1, '1);
    send_word(ACT_INSERT, 0, 32'hA5A5_A5A5);
    send_word(ACT_INSERT, 1, 32'h5A5A_5A5A);
    send_word(ACT_READ, 0, '0);
    send_word(ACT_READ, 3, '0);
    send_word(ACT_READ, 4, '0);
    send_word(ACT_READ, 127, '0);
    send_word(ACT_INSERT, 127, '1);
    send_word(ACT_INSERT, 5, 32'hDEAD_BEEF);
    send_word(ACT_DELETE, 1, '0);
    send_word(ACT_DELETE, 2, '0);
    send_word(ACT_DELETE, 0, '0);
    send_word(ACT_DELETE, 1, '0);
    send_word(ACT_READ, 0, '0);
    send_word(ACT_CLEAR, 0, '0);
    send_word(ACT_READ, 0, '0);
    wait_drained();

    while (words_sent < TOTAL_WORDS) begin
      allow_gaps = (words_sent < TOTAL_WORDS - CALM_TAIL);
      if (phase_no == 0 || $urandom_range(0, 9) == 0) begin
        fill_and_probe();
      end else begin
        kind    = phase_kind_t'($urandom_range(0, 2));
        run_len = $urandom_range(15, 40);
        repeat (run_len) begin
          act = pick_action(kind);
          send_word(act, pick_position(act), pick_value());
        end
      end
      phase_no++;
      // Now and then let every outstanding result come back before going on.
      if (phase_no == 3 || (allow_gaps && $urandom_range(0, 7) == 0)) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: positional_list_store_unit.f
+incdir+rtl
rtl/plst_pkg.sv
rtl/plst_ram.sv
rtl/positional_list_store_unit.sv
tb/positional_list_store_checker.sv
tb/positional_list_store_unit_tb.sv
